/* hdl/bhs_pkg.sv */
// Shared types and constants of the bucketed hash set.
package bhs_pkg;

    localparam int BC_W    = 9;   // bucket count register width
    localparam int KEY_W   = 32;  // key field width
    localparam int BIDX_W  = 8;   // reported bucket index width
    localparam int OP_W    = 2;   // opcode width
    localparam int DIGIT_W = 4;   // quotient bits retired per modulo step
    localparam int REM_W   = BC_W + 1;

    localparam logic [BC_W-1:0] BC_RESET = 9'd16;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_ADD   = 2'd0;
    localparam t_op OP_QUERY = 2'd1;
    localparam t_op OP_ERASE = 2'd2;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_MOD,
        S_RD,
        S_SCAN,
        S_UPD,
        S_OUT
    } t_state;

endpackage

/* hdl/bhs_req_if.sv */
// Request channel: opcode and key with a valid/ready handshake.
interface bhs_req_if;
    import bhs_pkg::*;

    logic             valid;
    logic             ready;
    t_op              opcode;
    logic [KEY_W-1:0] key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

/* hdl/bhs_rsp_if.sv */
// Result channel: membership, bucket index and status with a valid/ready handshake.
interface bhs_rsp_if;
    import bhs_pkg::*;

    logic              valid;
    logic              ready;
    logic              was_present;
    logic [BIDX_W-1:0] bucket_index;
    logic              status;

    modport source (output valid, output was_present, output bucket_index,
                    output status, input ready);
    modport sink   (input valid, input was_present, input bucket_index,
                    input status, output ready);
endinterface

/* hdl/bhs_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module bhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/bhs_mod.sv */
// Iterative modulo unit: remainder of a key by the bucket count, four bits per cycle.
module bhs_mod #(
    parameter int KW = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [KW-1:0]            i_dividend,
    input  logic [bhs_pkg::BC_W-1:0] i_divisor,
    output logic                     o_done,
    output logic [bhs_pkg::REM_W-1:0] o_rem
);
    import bhs_pkg::*;

    localparam int STEPS = (KW + DIGIT_W - 1) / DIGIT_W;
    localparam int DW    = STEPS * DIGIT_W;
    localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [DW-1:0]    r_div, n_div;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    always_comb begin
        logic [REM_W-1:0] rem;
        rem    = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_div  = DW'(i_dividend);
            n_cnt  = '0;
            n_busy = 1'b1;
            rem    = '0;
        end else if (r_busy) begin
            // Restoring long division; the remainder always stays below the divisor.
            for (int b = 0; b < DIGIT_W; b++) begin
                rem = {rem[REM_W-2:0], r_div[DW-1-b]};
                if (rem >= {1'b0, i_divisor}) begin
                    rem = rem - {1'b0, i_divisor};
                end
            end
            n_div = r_div << DIGIT_W;
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

/* hdl/bucketed_hash_set.sv */
// Bucketed hash set: fixed slots per bucket, identity hash modulo the bucket count.
// Each item goes through the modulo unit, which retires four quotient bits a cycle,
// a read of the bucket's valid row, a scan of its keys one slot at a time, the update of
// the table and the result, which is held until it is taken. Items are handled one at a
// time, each paced by the modulo iterations and by one key RAM read per slot of the bucket.
// Reset: synchronous, active low; the bucket count returns to 16 and a clearing pass over
// every bucket row empties the valid table, during which no request is accepted.
module bucketed_hash_set #(
    parameter int MAX_BUCKETS      = 256,
    parameter int SLOTS_PER_BUCKET = 4,
    parameter int KEY_BITS         = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [bhs_pkg::BC_W-1:0] i_cfg_wdata,
    bhs_req_if.sink                  i_req,
    bhs_rsp_if.source                o_rsp
);
    import bhs_pkg::*;

    // Stored key width: only the low KEY_BITS bits of a key take part.
    localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int SLOTS = SLOTS_PER_BUCKET;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TOTAL = MAX_BUCKETS * SLOTS;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;

    // Control state.
    t_state          r_state, n_state;
    logic [BC_W-1:0] r_bucket_count;
    logic [BW-1:0]   r_clr, n_clr;
    logic [SW-1:0]   r_slot, n_slot;
    logic            r_hit, n_hit;

    // Payload registers of the item in flight.
    t_op             r_op, n_op;
    logic [KW-1:0]   r_key, n_key;
    logic [BW-1:0]   r_bucket, n_bucket;
    logic [BIDX_W-1:0] r_bidx, n_bidx;
    logic [SW-1:0]   r_hit_slot, n_hit_slot;
    logic            r_was_present, n_was_present;
    logic            r_status, n_status;

    // Effective bucket count: zero counts as one, large values saturate.
    logic [BC_W-1:0] eff_buckets;

    always_comb begin
        if (r_bucket_count == '0) begin
            eff_buckets = BC_W'(1);
        end else if (32'(r_bucket_count) > MAX_BUCKETS) begin
            eff_buckets = BC_W'(MAX_BUCKETS);
        end else begin
            eff_buckets = r_bucket_count;
        end
    end

    // Modulo unit.
    logic             mod_start;
    logic             mod_done;
    logic [REM_W-1:0] mod_rem;

    bhs_mod #(.KW(KW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (KW'(i_req.key)),
        .i_divisor  (eff_buckets),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // Key store: one entry per slot, addressed bucket * SLOTS + slot.
    logic            key_we, key_re;
    logic [AW-1:0]   key_waddr, key_raddr, row_base;
    logic [KW-1:0]   key_rdata;
    logic [SW-1:0]   rd_slot;
    logic [SW-1:0]   free_slot;
    logic            free_found;

    assign row_base  = AW'(r_bucket * SLOTS);
    assign key_raddr = row_base + AW'(rd_slot);
    assign key_waddr = row_base + AW'(free_slot);

    bhs_ram #(.WIDTH(KW), .DEPTH(TOTAL)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (r_key),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    // Valid table: one row of slot valid bits per bucket, cleared after reset.
    logic             vld_we, vld_re;
    logic [BW-1:0]    vld_waddr;
    logic [SLOTS-1:0] vld_wdata, vld_row;

    bhs_ram #(.WIDTH(SLOTS), .DEPTH(MAX_BUCKETS)) u_vld_ram (
        .i_clk   (i_clk),
        .i_we    (vld_we),
        .i_waddr (vld_waddr),
        .i_wdata (vld_wdata),
        .i_re    (vld_re),
        .i_raddr (r_bucket),
        .o_rdata (vld_row)
    );

    // Lowest free slot of the bucket row.
    always_comb begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!vld_row[s]) begin
                free_slot  = SW'(s);
                free_found = 1'b1;
            end
        end
    end

    // Sequencer: next state, register updates and memory controls.
    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_slot        = r_slot;
        n_hit         = r_hit;
        n_op          = r_op;
        n_key         = r_key;
        n_bucket      = r_bucket;
        n_bidx        = r_bidx;
        n_hit_slot    = r_hit_slot;
        n_was_present = r_was_present;
        n_status      = r_status;
        mod_start     = 1'b0;
        key_we        = 1'b0;
        key_re        = 1'b0;
        rd_slot       = r_slot;
        vld_we        = 1'b0;
        vld_re        = 1'b0;
        vld_waddr     = r_bucket;
        vld_wdata     = vld_row;
        i_req.ready   = 1'b0;
        o_rsp.valid   = 1'b0;

        case (r_state)
            S_CLR: begin
                // Sweep every bucket row to empty, one row a cycle.
                vld_we    = 1'b1;
                vld_waddr = r_clr;
                vld_wdata = '0;
                n_clr     = r_clr + BW'(1);
                if (r_clr == BW'(MAX_BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_op      = i_req.opcode;
                    n_key     = KW'(i_req.key);
                    mod_start = 1'b1;
                    n_state   = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_bucket = BW'(mod_rem);
                    n_bidx   = BIDX_W'(mod_rem);
                    n_state  = S_RD;
                end
            end
            S_RD: begin
                // Fetch the valid row and the first slot's key.
                vld_re  = 1'b1;
                key_re  = 1'b1;
                rd_slot = '0;
                n_slot  = '0;
                n_hit   = 1'b0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // key_rdata holds slot r_slot; the next slot is fetched alongside.
                if (!r_hit && vld_row[r_slot] && key_rdata == r_key) begin
                    n_hit      = 1'b1;
                    n_hit_slot = r_slot;
                end
                if (r_slot == SW'(SLOTS - 1)) begin
                    n_state = S_UPD;
                end else begin
                    rd_slot = r_slot + SW'(1);
                    key_re  = 1'b1;
                    n_slot  = r_slot + SW'(1);
                end
            end
            S_UPD: begin
                n_was_present = r_hit;
                n_status      = ST_OK;
                if (r_op == OP_ADD && !r_hit) begin
                    if (free_found) begin
                        key_we               = 1'b1;
                        vld_we               = 1'b1;
                        vld_wdata[free_slot] = 1'b1;
                    end else begin
                        n_status = ST_FULL;
                    end
                end else if (r_op == OP_ERASE && r_hit) begin
                    vld_we                = 1'b1;
                    vld_wdata[r_hit_slot] = 1'b0;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                o_rsp.valid = 1'b1;
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLR;
            r_clr          <= '0;
            r_slot         <= '0;
            r_hit          <= 1'b0;
            r_bucket_count <= BC_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_slot  <= n_slot;
            r_hit   <= n_hit;
            if (i_cfg_we) begin
                r_bucket_count <= i_cfg_wdata;
            end
        end
        r_op          <= n_op;
        r_key         <= n_key;
        r_bucket      <= n_bucket;
        r_bidx        <= n_bidx;
        r_hit_slot    <= n_hit_slot;
        r_was_present <= n_was_present;
        r_status      <= n_status;
    end

    assign o_rsp.was_present  = r_was_present;
    assign o_rsp.bucket_index = r_bidx;
    assign o_rsp.status       = r_status;
endmodule

/* tb/bucketed_hash_set_test.sv */
// Self-checking testbench of the bucketed hash set with a behavioral table predictor.
`timescale 1ns / 100ps

module bucketed_hash_set_test;
    import bhs_pkg::*;

    // Block geometry as instantiated below.
    localparam int MAX_BKT   = 256;
    localparam int SLOTS     = 4;
    localparam int SLOT_CNT  = MAX_BKT * SLOTS;

    // The fourth opcode is not named by the package; the block treats it as a query.
    localparam t_op OP_RSVD = 2'd3;

    // Run control.
    localparam int    HOLD_CYCLES  = 400;      // long receiver hold-off
    localparam int    TAIL_CYCLES  = 40;       // settle time after the last result
    localparam int    RAND_PHASES  = 15;
    localparam int    PHASE_ITEMS  = 30;
    localparam int    POOL_SIZE    = 32;
    localparam int    MAX_REPORTS  = 10;
    localparam longint TIMEOUT_NS  = 64'd5_000_000;

    // One result as the block reports it.
    typedef struct packed {
        logic              was_present;
        logic [BIDX_W-1:0] bucket_index;
        logic              status;
    } t_rsp;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [BC_W-1:0]  i_cfg_wdata;

    bhs_req_if req_ch ();
    bhs_rsp_if rsp_ch ();

    bucketed_hash_set #(
        .MAX_BUCKETS      (MAX_BKT),
        .SLOTS_PER_BUCKET (SLOTS),
        .KEY_BITS         (KEY_W)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // Shadow copy of the table and of the bucket count register.
    logic [KEY_W-1:0] table_key  [SLOT_CNT];
    bit               table_used [SLOT_CNT];
    logic [BC_W-1:0]  table_buckets;

    // Results predicted for accepted items, oldest first.
    t_rsp pending_rsp [$];

    // Keys of the current phase, clustered into a few buckets so that they collide.
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int errors;
    int n_add, n_query, n_erase, n_other, n_hits, n_full, n_settings;

    // Receiver behavior: a long hold-off driven by its own process, a quiet mode
    // without random stalls, and the length of the current random stall.
    logic rsp_hold;
    logic rsp_quiet;
    int   rsp_gap;

    // The clock runs freely from time zero.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run time, far beyond the slowest correct run.
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", pending_rsp.size());
        $display("status: fail");
        $finish;
    end

    // The register saturates at the table size and treats zero as a single bucket.
    function automatic int unsigned buckets_in_use(input logic [BC_W-1:0] count);
        if (count == '0)
            return 1;
        if (count > MAX_BKT)
            return MAX_BKT;
        return 32'(count);
    endfunction

    // Applies one request to the shadow table and returns the result it causes.
    function automatic t_rsp apply_request(input t_op op, input logic [KEY_W-1:0] key);
        int unsigned nb;
        int unsigned bucket;
        int unsigned base;
        int          hit;
        int          free_slot;
        t_rsp        r;
        nb        = buckets_in_use(table_buckets);
        bucket    = key % nb;
        base      = bucket * SLOTS;
        hit       = -1;
        free_slot = -1;
        // A key is only compared while its slot is in use, so unwritten keys are never read.
        for (int s = 0; s < SLOTS; s++) begin
            if (table_used[base + s]) begin
                if (hit < 0 && table_key[base + s] == key)
                    hit = s;
            end else if (free_slot < 0) begin
                free_slot = s;
            end
        end
        r.was_present  = (hit >= 0);
        r.bucket_index = bucket[BIDX_W-1:0];
        r.status       = ST_OK;
        if (op == OP_ADD && hit < 0) begin
            if (free_slot >= 0) begin
                table_key[base + free_slot]  = key;
                table_used[base + free_slot] = 1'b1;
            end else begin
                r.status = ST_FULL;
            end
        end else if (op == OP_ERASE && hit >= 0) begin
            table_used[base + hit] = 1'b0;
        end
        return r;
    endfunction

    // Idle lengths are drawn from three ranges, the shortest most often, the longest rarely.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 15);
        return $urandom_range(40, 120);
    endfunction

    // Offers one item and waits until the block takes it; the prediction is made at
    // the accepting edge so that it sees the table in the order the block does.
    // Valid stays high on return so that a following item can go out back to back.
    task automatic send_request(input t_op op, input logic [KEY_W-1:0] key);
        t_rsp r;
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.key    <= key;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1)
            @(posedge i_clk);
        r = apply_request(op, key);
        pending_rsp.push_back(r);
        case (op)
            OP_ADD:   n_add++;
            OP_QUERY: n_query++;
            OP_ERASE: n_erase++;
            default:  n_other++;
        endcase
        if (r.was_present)
            n_hits++;
        if (r.status == ST_FULL)
            n_full++;
    endtask

    // Random gap on the request side; in quiet mode items follow back to back.
    // Payload lines carry noise while valid is low.
    task automatic sender_gap();
        int n;
        n = 0;
        if (!rsp_quiet && $urandom_range(0, 99) < 50)
            n = idle_len();
        if (n > 0) begin
            req_ch.valid  <= 1'b0;
            req_ch.opcode <= t_op'($urandom_range(0, 3));
            req_ch.key    <= $urandom();
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stops offering items and waits until every predicted result has been checked.
    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge i_clk);
    endtask

    // The register is only written with the block idle, so drain first.
    task automatic set_bucket_count(input logic [BC_W-1:0] value);
        wait_all_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        table_buckets = value;
        n_settings++;
    endtask

    // Builds a pool of keys for the current bucket count: six buckets get five keys
    // each, one more than a bucket holds, and two keys are fully random.
    task automatic build_key_pool();
        int unsigned nb;
        int unsigned b;
        int unsigned span;
        int          i;
        nb = buckets_in_use(table_buckets);
        i  = 0;
        for (int g = 0; g < 6; g++) begin
            b    = $urandom_range(0, nb - 1);
            span = (32'hFFFF_FFFF - b) / nb;
            for (int j = 0; j < 5; j++) begin
                key_pool[i] = b + nb * $urandom_range(0, span);
                i++;
            end
        end
        while (i < POOL_SIZE) begin
            key_pool[i] = $urandom();
            i++;
        end
    endtask

    function automatic t_op pick_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return OP_ADD;
        if (r < 70)
            return OP_QUERY;
        if (r < 95)
            return OP_ERASE;
        return OP_RSVD;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 75)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    // Receiver: random stalls, none in quiet mode, and none while a hold-off runs,
    // during which ready stays low throughout.
    always @(posedge i_clk) begin
        if (rsp_hold) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_gap > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_gap      <= rsp_gap - 1;
        end else if (!rsp_quiet && $urandom_range(0, 99) < 25) begin
            rsp_ch.ready <= 1'b0;
            rsp_gap      <= idle_len() - 1;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Compares every accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_rsp exp_r;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_rsp.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result without a pending item: present=%b bucket=%0d st=%b",
                             $realtime, rsp_ch.was_present, rsp_ch.bucket_index,
                             rsp_ch.status);
            end else begin
                exp_r = pending_rsp.pop_front();
                if (rsp_ch.was_present !== exp_r.was_present ||
                    rsp_ch.bucket_index !== exp_r.bucket_index ||
                    rsp_ch.status !== exp_r.status) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: mismatch present %b/%b bucket %0d/%0d st %b/%b (exp/got)",
                                 $realtime, exp_r.was_present, rsp_ch.was_present,
                                 exp_r.bucket_index, rsp_ch.bucket_index,
                                 exp_r.status, rsp_ch.status);
                end
            end
        end
    end

    // Default bucket count of 16: basic membership, the reserved opcode, add of a
    // present key, add to a full bucket, erase of an absent key and the largest key.
    task automatic test_default_count();
        send_request(OP_QUERY, 32'd0);
        send_request(OP_ADD,   32'd0);
        send_request(OP_ADD,   32'd0);
        send_request(OP_ERASE, 32'd0);
        send_request(OP_ERASE, 32'd0);
        send_request(OP_RSVD,  32'd0);
        // Bucket 5 takes four keys; the fifth is dropped.
        send_request(OP_ADD,   32'd5);
        send_request(OP_ADD,   32'd21);
        send_request(OP_ADD,   32'd37);
        send_request(OP_ADD,   32'd53);
        send_request(OP_ADD,   32'd69);
        // A present key in a full bucket is a hit, not an overflow.
        send_request(OP_ADD,   32'd21);
        send_request(OP_ERASE, 32'd37);
        send_request(OP_ADD,   32'd69);
        send_request(OP_RSVD,  32'd69);
        send_request(OP_ADD,   32'hFFFF_FFFF);
        wait_all_results();
    endtask

    // Smallest and largest settings, including zero and a value above the table size,
    // and a change of the count while keys are stored.
    task automatic test_count_extremes();
        set_bucket_count(9'd1);
        send_request(OP_ADD,   32'd1);
        send_request(OP_ADD,   32'd2);
        send_request(OP_ADD,   32'd3);
        send_request(OP_ADD,   32'hFFFF_FFFF);
        send_request(OP_ADD,   32'd9);
        // Zero acts as one bucket, so the keys above are still found.
        set_bucket_count(9'd0);
        send_request(OP_QUERY, 32'd3);
        send_request(OP_ERASE, 32'd3);
        // Saturation: 511 maps like 256, and keys stored in bucket 0 are now missed.
        set_bucket_count(9'h1FF);
        send_request(OP_ADD,   32'hFFFF_FFFF);
        send_request(OP_QUERY, 32'd255);
        set_bucket_count(9'd256);
        send_request(OP_QUERY, 32'hFFFF_FFFF);
        wait_all_results();
    endtask

    // The receiver holds off for a long stretch while items keep coming, so the
    // result stays stuck and the block stops taking requests.
    task automatic test_backpressure();
        set_bucket_count(9'd8);
        build_key_pool();
        fork
            begin
                rsp_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rsp_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 10; i++)
            send_request(pick_opcode(), pick_key());
        wait_all_results();
    endtask

    // Random traffic over a series of bucket counts; keys mostly come from a pool
    // that collides within a few buckets, so hits, erases and overflows are common.
    task automatic test_random_traffic();
        logic [BC_W-1:0] counts [RAND_PHASES];
        counts = '{9'd16, 9'd4, 9'd256, 9'd1, 9'h1FF, 9'd0, 9'd2, 9'd255, 9'd3, 9'd128,
                   9'd0, 9'd0, 9'd0, 9'd0, 9'd0};
        for (int p = 10; p < RAND_PHASES; p++)
            counts[p] = (p == RAND_PHASES - 1) ? BC_W'($urandom())
                                               : BC_W'($urandom_range(1, 64));
        for (int p = 0; p < RAND_PHASES; p++) begin
            set_bucket_count(counts[p]);
            rsp_quiet <= (p % 4 == 3);
            build_key_pool();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_request(pick_opcode(), pick_key());
                // Now and then the sender pauses until everything has come back.
                if ($urandom_range(0, 99) < 3)
                    wait_all_results();
                else
                    sender_gap();
            end
        end
        rsp_quiet <= 1'b0;
        wait_all_results();
    endtask

    initial begin
        errors     = 0;
        n_add      = 0;
        n_query    = 0;
        n_erase    = 0;
        n_other    = 0;
        n_hits     = 0;
        n_full     = 0;
        n_settings = 0;
        rsp_gap    = 0;
        rsp_hold   = 1'b0;
        rsp_quiet  = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_wdata = '0;
        req_ch.valid  = 1'b0;
        req_ch.opcode = OP_QUERY;
        req_ch.key    = '0;
        rsp_ch.ready  = 1'b0;
        table_buckets = BC_RESET;
        for (int i = 0; i < SLOT_CNT; i++)
            table_used[i] = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first send waits out the clearing pass after reset on ready.
        test_default_count();
        test_count_extremes();
        test_backpressure();
        test_random_traffic();

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_rsp.size() != 0)
            errors++;

        $display("covered %0d items: %0d add, %0d query, %0d erase, %0d reserved opcode",
                 n_add + n_query + n_erase + n_other, n_add, n_query, n_erase, n_other);
        $display("%0d hits, %0d full-bucket drops, %0d bucket count writes, %0d errors",
                 n_hits, n_full, n_settings, errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
